// ----- hdl/qsd_pkg.sv -----
// Shared types, character codes and decode helpers for the query string decoder.
package qsd_pkg;

   localparam int QueueDepth = 4;
   localparam int MaxResults = 4;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_PCT  = 2'd1;
   localparam logic [1:0] HELD_BYTE = 2'd2;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       pair_ok;
      logic       query_done;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] res;
      logic [2:0]                  count;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] val;
   } decoded_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_val(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Leading hex digit, or whitespace / sign prefix followed by a hex digit.
   function automatic decoded_type esc_decode(input logic [7:0] a, input logic [7:0] b);
      hex_type     ha;
      hex_type     hb;
      decoded_type d;
      ha    = hex_val(a);
      hb    = hex_val(b);
      d.ok  = 1'b0;
      d.val = 8'd0;
      if (ha.ok) begin
         d.ok  = 1'b1;
         d.val = hb.ok ? {ha.val, hb.val} : {4'd0, ha.val};
      end else if (hb.ok && (is_ws(a) || a == CH_PLUS)) begin
         d.ok  = 1'b1;
         d.val = {4'd0, hb.val};
      end else if (hb.ok && a == CH_MINUS) begin
         d.ok  = 1'b1;
         d.val = 8'd0 - {4'd0, hb.val};
      end
      return d;
   endfunction

   function automatic logic [7:0] plain_map(input logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
   endfunction

endpackage

// ----- hdl/query_string_decoder.sv -----
// Top level of the query string decoder: front end, result queue and back end.
// Path: a byte's results are written into the queue, then loaded into the result register.
// Throughput: one byte per cycle while the queue is not full; the back end sends one result
// per cycle while rsp_ready is high, and the queue of QUEUE_DEPTH groups absorbs bursts.
// Reset: clears the key/value part, the pending escape, the queue and the result valid flag.
module query_string_decoder
   import qsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_pair_ok,
   output logic       rsp_run_last,
   output logic       rsp_query_done
);

   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      full;
   logic      empty;

   qsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte   (req_byte),
      .req_final  (req_final),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   qsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   qsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_kind       (rsp_kind),
      .rsp_pair_ok    (rsp_pair_ok),
      .rsp_run_last   (rsp_run_last),
      .rsp_query_done (rsp_query_done)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result group pushed into a full queue");

   a_pushed_group_size: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_entry.count >= 3'd1 && push_entry.count <= 3'd4))
      else $error("result group size out of range");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_query_done |-> rsp_kind == KIND_END && rsp_run_last)
      else $error("query end not on the last pair-end result of its byte");

   a_byte_flags_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_END |-> !rsp_pair_ok && !rsp_query_done)
      else $error("pair flags set on a byte result");

endmodule

// ----- hdl/qsd_front.sv -----
// Front end: tracks pair and escape state and turns each byte into a result group.
module qsd_front
   import qsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_final,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic        vp_ff, vp_in;
   logic [1:0]  hc_ff, hc_in;
   logic [7:0]  hb_ff, hb_in;
   logic        accept;

   result_type [MaxResults-1:0] res;
   logic [2:0]  n;
   logic        vp;
   logic [1:0]  hc;
   logic [7:0]  hb;
   decoded_type dec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      vp  = vp_ff;
      hc  = hc_ff;
      hb  = hb_ff;
      n   = 3'd0;
      res = '0;
      dec = esc_decode(hb_ff, req_byte);

      if (req_byte == CH_AMP || (req_byte == CH_EQ && !vp)) begin
         // Part ends: spill an incomplete escape raw.
         if (hc == HELD_BYTE) begin
            res[n[1:0]] = '{data: CH_PCT, kind: {1'b0, vp}, pair_ok: 1'b0, query_done: 1'b0};
            n = n + 3'd1;
            res[n[1:0]] = '{data: plain_map(hb), kind: {1'b0, vp}, pair_ok: 1'b0,
                            query_done: 1'b0};
            n = n + 3'd1;
         end else if (hc == HELD_PCT) begin
            res[n[1:0]] = '{data: CH_PCT, kind: {1'b0, vp}, pair_ok: 1'b0, query_done: 1'b0};
            n = n + 3'd1;
         end
         hc = HELD_NONE;
         if (req_byte == CH_AMP) begin
            res[n[1:0]] = '{data: 8'd0, kind: KIND_END, pair_ok: vp, query_done: req_final};
            n  = n + 3'd1;
            vp = 1'b0;
         end else begin
            vp = 1'b1;
         end
      end else begin
         if (hc != HELD_BYTE) begin
            if (hc == HELD_PCT) begin
               hb = req_byte;
               hc = HELD_BYTE;
            end else if (req_byte == CH_PCT) begin
               hc = HELD_PCT;
            end else begin
               res[n[1:0]] = '{data: plain_map(req_byte), kind: {1'b0, vp}, pair_ok: 1'b0,
                               query_done: 1'b0};
               n = n + 3'd1;
            end
         end else begin
            hc = HELD_NONE;
            if (dec.ok) begin
               res[n[1:0]] = '{data: dec.val, kind: {1'b0, vp}, pair_ok: 1'b0,
                               query_done: 1'b0};
               n = n + 3'd1;
            end else begin
               // Failed escape: emit '%' raw, rescan the held byte and this one.
               res[n[1:0]] = '{data: CH_PCT, kind: {1'b0, vp}, pair_ok: 1'b0,
                               query_done: 1'b0};
               n = n + 3'd1;
               if (hb_ff == CH_PCT) begin
                  hb = req_byte;
                  hc = HELD_BYTE;
               end else begin
                  res[n[1:0]] = '{data: plain_map(hb_ff), kind: {1'b0, vp}, pair_ok: 1'b0,
                                  query_done: 1'b0};
                  n = n + 3'd1;
                  if (req_byte == CH_PCT) begin
                     hc = HELD_PCT;
                  end else begin
                     res[n[1:0]] = '{data: plain_map(req_byte), kind: {1'b0, vp},
                                     pair_ok: 1'b0, query_done: 1'b0};
                     n = n + 3'd1;
                  end
               end
            end
         end
      end

      // Last byte of the string closes the open pair.
      if (req_final && req_byte != CH_AMP) begin
         if (hc == HELD_BYTE) begin
            res[n[1:0]] = '{data: CH_PCT, kind: {1'b0, vp}, pair_ok: 1'b0, query_done: 1'b0};
            n = n + 3'd1;
            res[n[1:0]] = '{data: plain_map(hb), kind: {1'b0, vp}, pair_ok: 1'b0,
                            query_done: 1'b0};
            n = n + 3'd1;
         end else if (hc == HELD_PCT) begin
            res[n[1:0]] = '{data: CH_PCT, kind: {1'b0, vp}, pair_ok: 1'b0, query_done: 1'b0};
            n = n + 3'd1;
         end
         hc = HELD_NONE;
         res[n[1:0]] = '{data: 8'd0, kind: KIND_END, pair_ok: vp, query_done: 1'b1};
         n  = n + 3'd1;
         vp = 1'b0;
      end

      vp_in = vp;
      hc_in = hc;
      hb_in = hb;
   end

   assign push             = accept && (n != 3'd0);
   assign push_entry.res   = res;
   assign push_entry.count = n;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         hc_ff <= HELD_NONE;
      end else if (accept) begin
         vp_ff <= vp_in;
         hc_ff <= hc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hb_ff <= hb_in;
      end
   end

endmodule

// ----- hdl/qsd_queue.sv -----
// Short queue of result groups between the front end and the back end.
module qsd_queue
   import qsd_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ff, wr_in;
   logic [PtrW-1:0]  rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_pop;

   assign full   = (cnt_ff == CntW'(DEPTH));
   assign empty  = (cnt_ff == '0);
   assign head   = mem_ff[rd_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in  = push ? ((wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CntW'(push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/qsd_back.sv -----
// Back end: steps through each queued group and drives the result register.
module qsd_back
   import qsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_pair_ok,
   output logic       rsp_run_last,
   output logic       rsp_query_done
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       last;
   result_type cur;
   result_type out_ff;
   logic       run_last_ff;

   assign cur  = head.res[idx_ff];
   assign last = ({1'b0, idx_ff} == head.count - 3'd1);
   assign load = !empty && (!valid_ff || rsp_ready);
   assign pop  = load && last;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      idx_in   = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff      <= cur;
         run_last_ff <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_byte       = out_ff.data;
   assign rsp_kind       = out_ff.kind;
   assign rsp_pair_ok    = out_ff.pair_ok;
   assign rsp_query_done = out_ff.query_done;
   assign rsp_run_last   = run_last_ff;

endmodule

// ----- tb/tb_query_string_decoder.sv -----
// Self-checking testbench for the query string decoder: directed rows, random queries.
`timescale 1ns / 1ps

module tb_query_string_decoder;
   import qsd_pkg::*;

   localparam int HalfPeriod     = 2;
   localparam int ResetCycles    = 11;
   localparam int LongHoldCycles = 80;
   localparam int DrainCycles    = 8;
   localparam int WatchdogLimit  = 400;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       pair_ok;
      logic       run_last;
      logic       query_done;
   } output_item_type;

   typedef struct packed {
      logic [7:0]      raw;
      logic            last;
      logic            typed;
      output_item_type want;
   } query_item_type;

   localparam output_item_type NoExpectation = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte = 8'd0;
   logic       req_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte;
   logic [1:0] rsp_kind;
   logic       rsp_pair_ok;
   logic       rsp_run_last;
   logic       rsp_query_done;

   query_string_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte       (req_byte),
      .req_final      (req_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_kind       (rsp_kind),
      .rsp_pair_ok    (rsp_pair_ok),
      .rsp_run_last   (rsp_run_last),
      .rsp_query_done (rsp_query_done)
   );

   always #HalfPeriod clock = ~clock;

   // Columns: raw byte, final, typed, then the typed result (data, kind, ok, last, done).
   query_item_type directed_rows [26] = '{
      {"a",      1'b0, 1'b1, "a",      KIND_KEY,   3'b010},
      {8'h00,    1'b0, 1'b1, 8'h00,    KIND_KEY,   3'b010},
      {8'hFF,    1'b0, 1'b1, 8'hFF,    KIND_KEY,   3'b010},
      {CH_PLUS,  1'b0, 1'b1, CH_SPACE, KIND_KEY,   3'b010},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {"4",      1'b0, 1'b0, NoExpectation},
      {"1",      1'b0, 1'b0, NoExpectation},
      {CH_EQ,    1'b0, 1'b0, NoExpectation},
      {CH_EQ,    1'b0, 1'b0, NoExpectation},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {CH_MINUS, 1'b0, 1'b0, NoExpectation},
      {"5",      1'b0, 1'b0, NoExpectation},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {CH_SPACE, 1'b0, 1'b0, NoExpectation},
      {"z",      1'b0, 1'b0, NoExpectation},
      {CH_AMP,   1'b0, 1'b1, 8'h00,    KIND_END,   3'b110},
      {CH_AMP,   1'b0, 1'b1, 8'h00,    KIND_END,   3'b010},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {"a",      1'b0, 1'b0, NoExpectation},
      {"g",      1'b0, 1'b0, NoExpectation},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {"z",      1'b0, 1'b0, NoExpectation},
      {CH_PCT,   1'b1, 1'b0, NoExpectation},
      {CH_PCT,   1'b0, 1'b0, NoExpectation},
      {CH_EQ,    1'b0, 1'b0, NoExpectation},
      {CH_AMP,   1'b1, 1'b1, 8'h00,    KIND_END,   3'b111}
   };

   query_item_type  query_stream[$];
   output_item_type pending_results[$];
   output_item_type step_results[$];

   // Decoder state as the predictor sees it.
   logic       value_part = 1'b0;
   logic [1:0] held_count = HELD_NONE;
   logic [7:0] held_char  = 8'd0;

   bit sender_gaps      = 1'b1;
   bit receiver_stalls  = 1'b1;
   bit hold_off_request = 1'b0;
   int failures         = 0;
   int quiet_cycles     = 0;

   function automatic void emit_result(logic [7:0] data, logic [1:0] kind, logic ok,
                                       logic done);
      output_item_type r;
      r = {data, kind, ok, 1'b0, done};
      step_results.insert(step_results.size(), r);
   endfunction

   function automatic logic [1:0] part_kind();
      return value_part ? KIND_VALUE : KIND_KEY;
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic bit escape_value(logic [7:0] lead, logic [7:0] next,
                                       output logic [7:0] value);
      int hl;
      int hn;
      hl    = hex_digit(lead);
      hn    = hex_digit(next);
      value = 8'd0;
      if (hl >= 0) begin
         value = (hn >= 0) ? 8'(hl * 16 + hn) : 8'(hl);
         return 1'b1;
      end
      if (hn < 0) return 1'b0;
      if (lead == CH_SPACE || (lead >= 8'd9 && lead <= 8'd13) || lead == CH_PLUS) begin
         value = 8'(hn);
         return 1'b1;
      end
      if (lead == CH_MINUS) begin
         value = 8'(256 - hn);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Scan one ordinary byte; at most a percent sign is held here.
   function automatic void scan_plain(logic [7:0] c);
      if (held_count == HELD_PCT) begin
         held_char  = c;
         held_count = HELD_BYTE;
      end else if (c == CH_PLUS) begin
         emit_result(CH_SPACE, part_kind(), 1'b0, 1'b0);
      end else if (c == CH_PCT) begin
         held_count = HELD_PCT;
      end else begin
         emit_result(c, part_kind(), 1'b0, 1'b0);
      end
   endfunction

   function automatic void feed_byte(logic [7:0] c);
      logic [7:0] lead;
      logic [7:0] value;
      if (held_count != HELD_BYTE) begin
         scan_plain(c);
         return;
      end
      lead       = held_char;
      held_count = HELD_NONE;
      if (escape_value(lead, c, value)) begin
         emit_result(value, part_kind(), 1'b0, 1'b0);
      end else begin
         // Failed escape: send the percent sign raw and rescan both bytes.
         emit_result(CH_PCT, part_kind(), 1'b0, 1'b0);
         scan_plain(lead);
         scan_plain(c);
      end
   endfunction

   function automatic void flush_part();
      if (held_count == HELD_BYTE) begin
         held_count = HELD_NONE;
         emit_result(CH_PCT, part_kind(), 1'b0, 1'b0);
         scan_plain(held_char);
      end
      if (held_count == HELD_PCT) emit_result(CH_PCT, part_kind(), 1'b0, 1'b0);
      held_count = HELD_NONE;
   endfunction

   function automatic void end_pair(logic done);
      flush_part();
      emit_result(8'd0, KIND_END, value_part, done);
      value_part = 1'b0;
      held_count = HELD_NONE;
   endfunction

   function automatic void decode_byte(logic [7:0] c, logic last);
      step_results.delete();
      if (c == CH_AMP) begin
         end_pair(last);
      end else begin
         if (c == CH_EQ && !value_part) begin
            flush_part();
            value_part = 1'b1;
         end else begin
            feed_byte(c);
         end
         if (last) end_pair(1'b1);
      end
   endfunction

   function automatic void record_accept(query_item_type item);
      output_item_type r;
      decode_byte(item.raw, item.last);
      if (item.typed) begin
         pending_results.insert(pending_results.size(), item.want);
      end else begin
         foreach (step_results[i]) begin
            r          = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            pending_results.insert(pending_results.size(), r);
         end
      end
   endfunction

   function automatic logic [7:0] content_byte();
      string hex_chars = "0123456789abcdefABCDEF";
      int    pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return CH_PCT;
      if (pick < 50) return hex_chars[$urandom_range(0, 21)];
      if (pick < 58) return CH_PLUS;
      if (pick < 64) return CH_MINUS;
      if (pick < 67) return CH_SPACE;
      if (pick < 70) return 8'($urandom_range(9, 13));
      if (pick < 85) return 8'($urandom_range(8'h61, 8'h7A));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] noise_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return content_byte();
      if (pick < 7) return CH_EQ;
      if (pick < 9) return CH_AMP;
      return 8'($urandom_range(0, 255));
   endfunction

   // Mostly key=value pairs with escape-heavy content; now and then raw noise.
   task automatic add_query();
      logic [7:0]     text[$];
      int             pairs;
      query_item_type item;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 12)) text.insert(text.size(), noise_byte());
      end else begin
         pairs = $urandom_range(1, 3);
         for (int p = 0; p < pairs; p++) begin
            if (p != 0) text.insert(text.size(), CH_AMP);
            repeat ($urandom_range(0, 4)) text.insert(text.size(), content_byte());
            if ($urandom_range(0, 7) != 0) text.insert(text.size(), CH_EQ);
            repeat ($urandom_range(0, 5)) text.insert(text.size(), content_byte());
         end
      end
      foreach (text[i]) begin
         item = {text[i], 1'(i == text.size() - 1), 1'b0, NoExpectation};
         query_stream.insert(query_stream.size(), item);
      end
   endtask

   task automatic queue_queries(int count);
      while (query_stream.size() < count) add_query();
   endtask

   task automatic send_stream();
      query_item_type item;
      while (query_stream.size() != 0) begin
         item = query_stream.pop_front();
         if (sender_gaps && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_byte  <= item.raw;
         req_final <= item.last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         record_accept(item);
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      output_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: byte %0h kind %0d", rsp_byte, rsp_kind);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_byte", want.data, rsp_byte);
            check_field("kind", want.kind, rsp_kind);
            check_field("pair_ok", want.pair_ok, rsp_pair_ok);
            check_field("run_last", want.run_last, rsp_run_last);
            check_field("query_done", want.query_done, rsp_query_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      wait (!reset);
      forever begin
         if (hold_off_request) begin
            // Long hold: let the result queue fill and back up into the input.
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : main_sequence
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) query_stream.insert(query_stream.size(), directed_rows[i]);
      send_stream();

      queue_queries(120);
      send_stream();

      // Hold the input until every expected result is out.
      while (pending_results.size() != 0) @(posedge clock);

      sender_gaps      = 1'b0;
      hold_off_request = 1'b1;
      queue_queries(50);
      send_stream();

      sender_gaps = 1'b1;
      queue_queries(110);
      send_stream();

      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      queue_queries(45);
      send_stream();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/qsd_pkg.sv
hdl/qsd_front.sv
hdl/qsd_queue.sv
hdl/qsd_back.sv
hdl/query_string_decoder.sv
tb/tb_query_string_decoder.sv
